// ===== src/sfla_pkg.sv =====
// ----------------------------------------------------------------------------
// sfla_pkg
// Types and constants shared by the slot free list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

	localparam int SLOT_W      = 8;
	localparam int VER_W       = 32;
	localparam int TABLE_DEPTH = 1 << SLOT_W;
	localparam int CNT_W       = SLOT_W + 1;

	typedef enum logic [1:0] {
		CMD_RESERVE = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_QUERY   = 2'd2,
		CMD_INIT    = 2'd3
	} cmd_e_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_EMPTY   = 2'd2
	} status_e_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SWEEP
	} state_e_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic exec_en;
		logic sweep_start;
		logic sweep_en;
		logic load_out;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic fin;
		logic is_init;
		logic sweep_last;
	} dp_stat_t;

endpackage

// ===== src/sfla_if.sv =====
// ----------------------------------------------------------------------------
// sfla request and response channels
// Valid/ready channels carrying the allocator requests and results.
// ----------------------------------------------------------------------------
interface sfla_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] slot;

	modport source (output valid, output command, output slot, input ready);
	modport sink   (input valid, input command, input slot, output ready);
endinterface

interface sfla_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  granted_slot;
	logic        is_occupied;
	logic [7:0]  used_slots;
	logic [31:0] change_version;

	modport source (
		output valid, output status, output granted_slot, output is_occupied,
		output used_slots, output change_version, input ready
	);
	modport sink (
		input valid, input status, input granted_slot, input is_occupied,
		input used_slots, input change_version, output ready
	);
endinterface

// ===== src/sfla_datapath.sv =====
// ----------------------------------------------------------------------------
// sfla_datapath
// Link and occupied-mark memories, list head, counters and result register.
// ----------------------------------------------------------------------------
module sfla_datapath
	import sfla_pkg::*;
#(
	parameter int MAX_SLOTS = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write_en,
	input  logic [SLOT_W-1:0]   cfg_write_data,
	input  logic [1:0]          req_command,
	input  logic [SLOT_W-1:0]   req_slot,
	input  ctl_cmd_t            cmd,
	output dp_stat_t            stat,
	output logic [1:0]          rsp_status,
	output logic [SLOT_W-1:0]   rsp_granted_slot,
	output logic                rsp_is_occupied,
	output logic [SLOT_W-1:0]   rsp_used_slots,
	output logic [VER_W-1:0]    rsp_change_version
);

	localparam int SLOT_MAX = TABLE_DEPTH - 1;
	localparam logic [SLOT_W-1:0] CAP_LIMIT =
		(MAX_SLOTS > SLOT_MAX) ? SLOT_W'(SLOT_MAX) : SLOT_W'(MAX_SLOTS);

	logic [SLOT_W-1:0] link_mem [TABLE_DEPTH];
	logic              tk_mem   [TABLE_DEPTH];

	logic [SLOT_W-1:0] cap_q, sweep_cap_q, sweep_idx_q, head_q, used_q;
	logic [VER_W-1:0]  ver_q;
	cmd_e_t            cmd_q;
	logic [SLOT_W-1:0] slot_q, cur_q, prev_q, link_rd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              taken_rd_q;

	logic [1:0]        res_status_q;
	logic [SLOT_W-1:0] res_granted_q, res_used_q;
	logic              res_occ_q;
	logic [VER_W-1:0]  res_ver_q;

	logic [SLOT_W-1:0] eff_cap, head_nxt, used_nxt, granted;
	logic [VER_W-1:0]  ver_nxt;
	status_e_t         st;
	logic              fin, adv, occ, in_range, taken_now;
	logic              step_link_we, step_tk_we, step_tk_wd;
	logic [SLOT_W-1:0] step_link_wa, step_link_wd, step_tk_wa;
	logic              link_we, tk_we, tk_wd, link_re;
	logic [SLOT_W-1:0] link_wa, link_wd, tk_wa, link_ra, sweep_link;

	assign eff_cap   = (cap_q > CAP_LIMIT) ? CAP_LIMIT : cap_q;
	assign in_range  = (slot_q != '0) && (slot_q <= eff_cap);
	assign taken_now = in_range && taken_rd_q;

	// one step of the current request, using the registered memory reads
	always_comb begin
		fin          = 1'b0;
		adv          = 1'b0;
		st           = ST_OK;
		granted      = '0;
		occ          = 1'b0;
		head_nxt     = head_q;
		used_nxt     = used_q;
		ver_nxt      = ver_q;
		step_link_we = 1'b0;
		step_link_wa = slot_q;
		step_link_wd = head_q;
		step_tk_we   = 1'b0;
		step_tk_wa   = slot_q;
		step_tk_wd   = 1'b0;
		case (cmd_q)
			CMD_QUERY: begin
				fin = 1'b1;
				occ = taken_now;
			end
			CMD_RELEASE: begin
				fin = 1'b1;
				if (taken_now) begin
					step_link_we = 1'b1;
					step_tk_we   = 1'b1;
					head_nxt     = slot_q;
					used_nxt     = used_q - 1'b1;
					ver_nxt      = ver_q + 1'b1;
				end else begin
					st = ST_INVALID;
				end
			end
			CMD_RESERVE: begin
				if (slot_q == '0) begin
					fin = 1'b1;
					if (head_q == '0) begin
						st = ST_EMPTY;
					end else begin
						granted    = head_q;
						occ        = 1'b1;
						head_nxt   = link_rd_q;
						step_tk_we = 1'b1;
						step_tk_wa = head_q;
						step_tk_wd = 1'b1;
						used_nxt   = used_q + 1'b1;
					end
				end else if (slot_q > eff_cap) begin
					fin = 1'b1;
					st  = ST_INVALID;
				end else if (taken_rd_q) begin
					fin = 1'b1;
					st  = ST_INVALID;
					occ = 1'b1;
				end else if (cur_q == '0 || cnt_q[CNT_W-1]) begin
					fin = 1'b1;
					st  = ST_INVALID;
				end else if (cur_q == slot_q) begin
					// unlink the named slot from the walk position
					fin        = 1'b1;
					granted    = slot_q;
					occ        = 1'b1;
					step_tk_we = 1'b1;
					step_tk_wd = 1'b1;
					used_nxt   = used_q + 1'b1;
					if (prev_q == '0) begin
						head_nxt = link_rd_q;
					end else begin
						step_link_we = 1'b1;
						step_link_wa = prev_q;
						step_link_wd = link_rd_q;
					end
				end else begin
					adv = 1'b1;
				end
			end
			default: begin
				// init runs as a sweep, result stays ok with zeroes
			end
		endcase
	end

	assign sweep_link = (sweep_idx_q >= sweep_cap_q) ? '0 : sweep_idx_q + 1'b1;

	always_comb begin
		if (cmd.sweep_en) begin
			link_we = 1'b1;
			link_wa = sweep_idx_q;
			link_wd = sweep_link;
			tk_we   = 1'b1;
			tk_wa   = sweep_idx_q;
			tk_wd   = 1'b0;
		end else begin
			link_we = step_link_we & cmd.exec_en;
			link_wa = step_link_wa;
			link_wd = step_link_wd;
			tk_we   = step_tk_we & cmd.exec_en;
			tk_wa   = step_tk_wa;
			tk_wd   = step_tk_wd;
		end
	end

	assign link_re = cmd.accept | (cmd.exec_en & adv);
	assign link_ra = cmd.accept ? head_q : link_rd_q;

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (link_re) begin
			link_rd_q <= link_mem[link_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (tk_we) begin
			tk_mem[tk_wa] <= tk_wd;
		end
		if (cmd.accept) begin
			taken_rd_q <= tk_mem[req_slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= '1;
			sweep_cap_q <= CAP_LIMIT;
			sweep_idx_q <= '0;
			head_q      <= SLOT_W'(1);
			used_q      <= '0;
			ver_q       <= '0;
		end else begin
			if (cfg_write_en) begin
				cap_q <= cfg_write_data;
			end
			if (cmd.sweep_en) begin
				sweep_idx_q <= sweep_idx_q + 1'b1;
			end
			if (cmd.sweep_start) begin
				sweep_idx_q <= '0;
				sweep_cap_q <= eff_cap;
				head_q      <= (eff_cap != '0) ? SLOT_W'(1) : '0;
				used_q      <= '0;
				ver_q       <= '0;
			end else if (cmd.exec_en) begin
				head_q <= head_nxt;
				used_q <= used_nxt;
				ver_q  <= ver_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q  <= cmd_e_t'(req_command);
			slot_q <= req_slot;
			cur_q  <= head_q;
			prev_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.exec_en && adv) begin
			prev_q <= cur_q;
			cur_q  <= link_rd_q;
			cnt_q  <= cnt_q + 1'b1;
		end
		if (cmd.load_out) begin
			res_status_q  <= st;
			res_granted_q <= granted;
			res_occ_q     <= occ;
			res_used_q    <= used_nxt;
			res_ver_q     <= ver_nxt;
		end
	end

	assign stat.fin        = fin;
	assign stat.is_init    = (cmd_q == CMD_INIT);
	assign stat.sweep_last = (sweep_idx_q == SLOT_W'(SLOT_MAX));

	assign rsp_status         = res_status_q;
	assign rsp_granted_slot   = res_granted_q;
	assign rsp_is_occupied    = res_occ_q;
	assign rsp_used_slots     = res_used_q;
	assign rsp_change_version = res_ver_q;

endmodule

// ===== src/sfla_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfla_ctrl
// Sequencer for accept, list walk, table sweep and result hand-off.
// ----------------------------------------------------------------------------
module sfla_ctrl
	import sfla_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	state_e_t state_q, state_nxt;
	logic     init_pend_q, init_pend_nxt;
	logic     out_valid_q, out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			init_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			init_pend_q <= init_pend_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt     = state_q;
		init_pend_nxt = init_pend_q;
		cmd           = '0;
		in_ready      = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.is_init) begin
					cmd.sweep_start = 1'b1;
					init_pend_nxt   = 1'b1;
					state_nxt       = S_SWEEP;
				end else if (!stat.fin) begin
					cmd.exec_en = 1'b1;
				end else if (out_free) begin
					// final step only commits once the result has somewhere to go
					cmd.exec_en  = 1'b1;
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			S_SWEEP: begin
				if (!stat.sweep_last) begin
					cmd.sweep_en = 1'b1;
				end else if (!init_pend_q) begin
					// sweep after reset gives no result
					cmd.sweep_en = 1'b1;
					state_nxt    = S_IDLE;
				end else if (out_free) begin
					cmd.sweep_en  = 1'b1;
					cmd.load_out  = 1'b1;
					init_pend_nxt = 1'b0;
					state_nxt     = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/slot_free_list_allocator_top.sv =====
// ----------------------------------------------------------------------------
// slot_free_list_allocator_top
// Free list slot allocator with a request and a response channel.
// ----------------------------------------------------------------------------
// One request at a time. Query, release and reserve of the list head are
// done in an accept and then one step on the registered read of the link
// and mark memories. A reserve of a named slot takes an accept and then one
// step per list node visited, plus one more step when the slot is not on
// the list; the walk is capped at 256 nodes. Init is accepted and then runs
// a sweep that rewrites every link and mark entry. After reset the same
// sweep runs before the first request is taken; capacity writes are taken
// during it. A finished result sits in an output register, so the next
// request is taken while it waits; an item only stalls on its final step if
// that register is still held.
module slot_free_list_allocator_top
	import sfla_pkg::*;
#(
	parameter int MAX_SLOTS = 255
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write_en,
	input  logic [SLOT_W-1:0] cfg_write_data,
	sfla_req_if.sink          req,
	sfla_rsp_if.source        rsp
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	sfla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sfla_datapath #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_write_en       (cfg_write_en),
		.cfg_write_data     (cfg_write_data),
		.req_command        (req.command),
		.req_slot           (req.slot),
		.cmd                (cmd),
		.stat               (stat),
		.rsp_status         (rsp.status),
		.rsp_granted_slot   (rsp.granted_slot),
		.rsp_is_occupied    (rsp.is_occupied),
		.rsp_used_slots     (rsp.used_slots),
		.rsp_change_version (rsp.change_version)
	);

endmodule

// ===== src/sfla_checker.sv =====
// ----------------------------------------------------------------------------
// sfla_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module sfla_checker
	import sfla_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic [7:0]  rsp_granted_slot,
	input logic        rsp_is_occupied,
	input logic [7:0]  rsp_used_slots,
	input logic [31:0] rsp_change_version
);

	// a granted slot always comes with ok and a set mark
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_granted_slot != '0) |->
			(rsp_status == ST_OK && rsp_is_occupied))
		else $error("granted slot without ok status or occupied mark");

	// empty list never grants
	a_empty_none: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status == ST_EMPTY) |->
			(rsp_granted_slot == '0 && !rsp_is_occupied))
		else $error("no-free-slots result carries a slot");

	// one request in flight: no accept right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while previous one still in progress");

	// a held result stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
			(rsp_valid && $stable(rsp_status) && $stable(rsp_granted_slot) &&
			 $stable(rsp_is_occupied) && $stable(rsp_used_slots) &&
			 $stable(rsp_change_version)))
		else $error("stalled result changed");

endmodule

bind slot_free_list_allocator_top sfla_checker u_sfla_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_status         (rsp.status),
	.rsp_granted_slot   (rsp.granted_slot),
	.rsp_is_occupied    (rsp.is_occupied),
	.rsp_used_slots     (rsp.used_slots),
	.rsp_change_version (rsp.change_version)
);
